FILE: rtl/mspi_pkg.sv
// Shared types and constants of the multi-slot interval profiler.
// Item payloads, action, status and register codes, fixed datapath widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mspi_pkg;

  localparam int FIELD_W   = 48;
  localparam int TOTAL_W   = 64;
  localparam int STOPS_W   = 32;
  localparam int ALU_W     = 64;
  localparam int DIV_STEPS = 64;
  localparam int CNT_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_VAL_W = 2;

  typedef enum logic [2:0] {
    ACT_START = 3'd0,
    ACT_STOP  = 3'd1,
    ACT_PAUSE = 3'd2,
    ACT_RESET = 3'd3,
    ACT_QUERY = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_INACTIVE      = 2'd1,
    ST_NEVER_STARTED = 2'd2,
    ST_NO_TIME       = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    TM_NONE = 2'd0,
    TM_CPU  = 2'd1,
    TM_REAL = 2'd2
  } tmode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE    = 2'd0,
    CFG_TIME_MODE = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]         action;
    logic [3:0]         slot;
    logic [FIELD_W-1:0] now;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] elapsed_ticks;
    logic [FIELD_W-1:0] last_ticks;
    logic [TOTAL_W-1:0] total_ticks;
    logic [FIELD_W-1:0] min_ticks;
    logic [FIELD_W-1:0] max_ticks;
    logic [TOTAL_W-1:0] average_ticks;
    logic [STOPS_W-1:0] stop_count;
    logic               is_paused;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_VAL_W-1:0] value;
  } cfg_item_t;

  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

endpackage

`default_nettype wire

FILE: rtl/mspi_stream_if.sv
// Valid/ready channel carrying one item of payload type T.
// Used for the input, result and configuration channels; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface mspi_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/mspi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mspi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/mspi_alu.sv
// Shared add/subtract unit with carry out.
// Depends on mspi_pkg for the request type and width.
`timescale 1ns / 1ps
`default_nettype none

module mspi_alu
  import mspi_pkg::*;
(
  input  alu_req_t       req_i,
  output logic [ALU_W:0] sum_o
);

  logic [ALU_W-1:0] b_inv;

  assign b_inv = req_i.b ^ {ALU_W{req_i.sub}};
  assign sum_o = {1'b0, req_i.a} + {1'b0, b_inv} + (ALU_W + 1)'(req_i.sub);

endmodule

`default_nettype wire

FILE: rtl/multi_slot_interval_profiler.sv
// Multi-slot interval profiler: a table of timing slots driven by a sequencer
// around one shared add/subtract unit. Depends on mspi_pkg, mspi_stream_if,
// mspi_ram and mspi_alu.
//
// Usage:
//   in_i   carries action, slot and the current tick stamp; one result item per
//          input item leaves on out_o. cfg_i writes enable and time_mode and is
//          always ready; write it only while the block is idle.
//   in_i is ready only when the sequencer is idle. A rejected item (inactive,
//   never started, no time source, unknown action) goes from idle straight to
//   the finish state and then to the output register. Start and reset step
//   through load and write; query load, lapse, write; pause load, lapse, total,
//   last, write; stop load, lapse, total, max, min, write. A nonzero stop count
//   adds a restoring division loop on the shared adder for the average.
//   Results wait in an output register; the next item is accepted while one
//   waits, and the sequencer holds its last step while the receiver stalls.
//   Reset clears all slots to never started, enable to 1 and time_mode to 0;
//   slot validity is held in flip-flops, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module multi_slot_interval_profiler
  import mspi_pkg::*;
#(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 48
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mspi_stream_if.sink   in_i,
  mspi_stream_if.source out_o,
  mspi_stream_if.sink   cfg_i
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef struct packed {
    logic                 paused;
    logic [STOPS_W-1:0]   stops;
    logic [TOTAL_W-1:0]   total;
    logic [TIME_BITS-1:0] last;
    logic [TIME_BITS-1:0] max;
    logic [TIME_BITS-1:0] min;
    logic [TIME_BITS-1:0] start;
  } rec_t;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_LOAD  = 10'b0000000010,
    S_LAPSE = 10'b0000000100,
    S_TOTAL = 10'b0000001000,
    S_LAST  = 10'b0000010000,
    S_MAX   = 10'b0000100000,
    S_MIN   = 10'b0001000000,
    S_WRITE = 10'b0010000000,
    S_DIV   = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_e;

  state_e               state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic [SLOTS-1:0]     known_q, known_d;
  logic                 enable_q, enable_d;
  logic [1:0]           time_mode_q, time_mode_d;

  logic [2:0]           act_q;
  logic [IDX_W-1:0]     idx_q;
  logic [TIME_BITS-1:0] now_q;
  logic                 hit_q;
  status_e              status_q;
  logic                 report_q;
  rec_t                 rec_q, rec_d, base_rec, rd_rec;
  logic [TIME_BITS-1:0] lapse_q, lapse_d;
  logic [STOPS_W-1:0]   rem_q, rem_d;
  logic [TOTAL_W-1:0]   quo_q, quo_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  out_item_t            out_q, out_d;
  logic                 out_load;

  logic                 in_acc;
  logic                 slot_in_range;
  logic [IDX_W-1:0]     in_idx;
  logic                 hit;
  logic                 has_time;
  status_e              chk_status;
  logic                 chk_report;
  logic                 clr;

  alu_req_t             alu_req;
  logic [ALU_W:0]       alu_sum;
  logic                 div_ge;

  logic                 ram_we;
  logic                 ram_re;
  logic [$bits(rec_t)-1:0] ram_rdata;

  mspi_alu u_alu (
    .req_i (alu_req),
    .sum_o (alu_sum)
  );

  mspi_ram #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (rec_q),
    .re_i    (ram_re),
    .raddr_i (in_idx),
    .rdata_o (ram_rdata)
  );

  assign rd_rec = rec_t'(ram_rdata);
  assign div_ge = alu_sum[ALU_W];

  // Acceptance checks
  assign in_i.ready    = (state_q == S_IDLE);
  assign in_acc        = in_i.valid && in_i.ready;
  assign slot_in_range = (32'(in_i.data.slot) < SLOTS);
  assign in_idx        = IDX_W'(in_i.data.slot);
  assign hit           = slot_in_range && known_q[in_idx];
  assign has_time      = (time_mode_q == TM_CPU) || (time_mode_q == TM_REAL);

  always_comb begin
    chk_status = ST_OK;
    chk_report = 1'b1;
    unique case (in_i.data.action)
      ACT_START: begin
        if (!enable_q) chk_status = ST_INACTIVE;
        else if (!has_time) chk_status = ST_NO_TIME;
        else if (!slot_in_range) chk_status = ST_NEVER_STARTED;
      end
      ACT_STOP, ACT_PAUSE: begin
        if (!enable_q) chk_status = ST_INACTIVE;
        else if (!has_time) chk_status = ST_NO_TIME;
        else if (!hit) chk_status = ST_NEVER_STARTED;
      end
      ACT_RESET: begin
        if (!enable_q) chk_status = ST_INACTIVE;
        else if (!hit) chk_status = ST_NEVER_STARTED;
      end
      ACT_QUERY: begin
        if (!hit) chk_status = ST_NEVER_STARTED;
        else if (!has_time) chk_status = ST_NO_TIME;
      end
      default: chk_report = 1'b0;
    endcase
    if (chk_status != ST_OK) begin
      chk_report = 1'b0;
    end
  end

  // Sequencer and datapath
  assign clr = (act_q == ACT_RESET) || ((act_q == ACT_START) && !hit_q);

  always_comb begin
    state_d  = state_q;
    rec_d    = rec_q;
    lapse_d  = lapse_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    known_d  = known_q;
    alu_req  = '0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    out_load = 1'b0;
    base_rec = clr ? '0 : rd_rec;

    unique case (state_q)
      S_IDLE: begin
        ram_re = in_acc;
        if (in_acc) begin
          state_d = chk_report ? S_LOAD : S_FIN;
        end
      end
      S_LOAD: begin
        rec_d = base_rec;
        if (act_q == ACT_START) begin
          rec_d.start  = now_q;
          if (!base_rec.paused) rec_d.last = '0;
          rec_d.paused = 1'b0;
        end
        if ((act_q == ACT_START) || (act_q == ACT_RESET)) state_d = S_WRITE;
        else state_d = S_LAPSE;
      end
      S_LAPSE: begin
        alu_req.a   = ALU_W'(now_q);
        alu_req.b   = ALU_W'(rec_q.start);
        alu_req.sub = 1'b1;
        lapse_d     = alu_sum[TIME_BITS-1:0];
        state_d     = (act_q == ACT_QUERY) ? S_WRITE : S_TOTAL;
      end
      S_TOTAL: begin
        alu_req.a   = rec_q.total;
        alu_req.b   = ALU_W'(lapse_q);
        rec_d.total = alu_sum[ALU_W] ? '1 : alu_sum[TOTAL_W-1:0];
        if (act_q == ACT_STOP) begin
          rec_d.last = lapse_q;
          if (rec_q.stops != '1) rec_d.stops = rec_q.stops + STOPS_W'(1);
          state_d = S_MAX;
        end else begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        alu_req.a    = ALU_W'(rec_q.last);
        alu_req.b    = ALU_W'(lapse_q);
        rec_d.last   = (alu_sum[ALU_W:TIME_BITS] != '0) ? '1 : alu_sum[TIME_BITS-1:0];
        rec_d.paused = 1'b1;
        state_d      = S_WRITE;
      end
      S_MAX: begin
        alu_req.a   = ALU_W'(lapse_q);
        alu_req.b   = ALU_W'(rec_q.max);
        alu_req.sub = 1'b1;
        if (alu_sum[ALU_W]) rec_d.max = lapse_q;
        state_d     = S_MIN;
      end
      S_MIN: begin
        alu_req.a   = ALU_W'(rec_q.min);
        alu_req.b   = ALU_W'(lapse_q);
        alu_req.sub = 1'b1;
        if (alu_sum[ALU_W] || (rec_q.min == '0)) rec_d.min = lapse_q;
        state_d     = S_WRITE;
      end
      S_WRITE: begin
        ram_we = (act_q != ACT_QUERY);
        if (act_q == ACT_START) known_d[idx_q] = 1'b1;
        rem_d   = '0;
        quo_d   = rec_q.total;
        cnt_d   = '0;
        state_d = (rec_q.stops == '0) ? S_FIN : S_DIV;
      end
      S_DIV: begin
        alu_req.a   = ALU_W'({rem_q, quo_q[TOTAL_W-1]});
        alu_req.b   = ALU_W'(rec_q.stops);
        alu_req.sub = 1'b1;
        rem_d = div_ge ? alu_sum[STOPS_W-1:0] : {rem_q[STOPS_W-2:0], quo_q[TOTAL_W-1]};
        quo_d = {quo_q[TOTAL_W-2:0], div_ge};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result assembly
  always_comb begin
    out_d        = '0;
    out_d.status = status_q;
    if (report_q) begin
      out_d.elapsed_ticks = (act_q == ACT_QUERY) ? FIELD_W'(lapse_q) : '0;
      out_d.last_ticks    = FIELD_W'(rec_q.last);
      out_d.total_ticks   = rec_q.total;
      out_d.min_ticks     = FIELD_W'(rec_q.min);
      out_d.max_ticks     = FIELD_W'(rec_q.max);
      out_d.average_ticks = (rec_q.stops == '0) ? '0 : quo_q;
      out_d.stop_count    = rec_q.stops;
      out_d.is_paused     = rec_q.paused;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.valid && out_o.ready) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_comb begin
    enable_d    = enable_q;
    time_mode_d = time_mode_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        CFG_ENABLE:    enable_d    = cfg_i.data.value[0];
        CFG_TIME_MODE: time_mode_d = cfg_i.data.value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      known_q     <= '0;
      enable_q    <= 1'b1;
      time_mode_q <= TM_NONE;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      known_q     <= known_d;
      enable_q    <= enable_d;
      time_mode_q <= time_mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q    <= in_i.data.action;
      idx_q    <= in_idx;
      now_q    <= TIME_BITS'(in_i.data.now);
      hit_q    <= hit;
      status_q <= chk_status;
      report_q <= chk_report;
    end
    rec_q   <= rec_d;
    lapse_q <= lapse_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    cnt_q   <= cnt_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire
